// ----- design/tca_pkg.sv -----
// ----------------------------------------------------------------------------
// tca_pkg
// Shared constants, codes and the command bundle for the tile cache tag store.
// ----------------------------------------------------------------------------
package tca_pkg;

  // Default sizing
  localparam int unsigned ENTRIES_DEF   = 8;
  localparam int unsigned AGE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TILE_W  = 16;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned FENT_W  = 3;
  localparam int unsigned OIDX_W  = 3;

  // Input beat packing
  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 24;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // Replacement modes
  localparam logic MODE_RR  = 1'b0;
  localparam logic MODE_AGE = 1'b1;

  // Command broadcast to every cell
  typedef struct packed {
    logic              fill;   // write tag and size into the selected cell
    logic              inval;  // clear valid of the selected cell
    logic              age;    // age every valid cell that misses the tag
    logic [ADDR_W-1:0] addr;
    logic [TILE_W-1:0] tile;
    logic [SIZE_W-1:0] size;
  } cmd_t;

endpackage

// ----- design/tca_cell.sv -----
// ----------------------------------------------------------------------------
// tca_cell
// One tag store entry. Folds its own entry into the search record that passes
// through it and hands the record to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module tca_cell
  import tca_pkg::*;
#(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned AGE_WIDTH = AGE_WIDTH_DEF,
  parameter int unsigned IDX       = 0,
  localparam int unsigned IW       = $clog2(ENTRIES),
  localparam int unsigned CW       = 1 + 1 + IW + SIZE_W + 1 + IW + 1 + IW + AGE_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic          sel_i,
  input  logic [CW-1:0] carry_i,
  output logic [CW-1:0] carry_o
);

  typedef struct packed {
    logic                 live;
    logic                 hit;
    logic [IW-1:0]        hit_idx;
    logic [SIZE_W-1:0]    hit_size;
    logic                 free;
    logic [IW-1:0]        free_idx;
    logic                 old;
    logic [IW-1:0]        old_idx;
    logic [AGE_WIDTH-1:0] old_age;
  } carry_t;

  logic                 valid_q, valid_d;
  logic [ADDR_W-1:0]    addr_q;
  logic [TILE_W-1:0]    tile_q;
  logic [SIZE_W-1:0]    size_q;
  logic [AGE_WIDTH-1:0] age_q, age_d;
  logic                 match;
  carry_t               cin, carry_d, carry_q;

  assign cin   = carry_t'(carry_i);
  assign match = valid_q && (addr_q == cmd_i.addr) && (tile_q == cmd_i.tile);

  // Fold this entry into the passing record; later cells win hit and free
  always_comb begin
    carry_d = cin;
    if (cin.live) begin
      if (match) begin
        carry_d.hit      = 1'b1;
        carry_d.hit_idx  = IW'(IDX);
        carry_d.hit_size = size_q;
      end else if (!valid_q) begin
        carry_d.free     = 1'b1;
        carry_d.free_idx = IW'(IDX);
      end else if (!cin.old || (age_q > cin.old_age)) begin
        carry_d.old      = 1'b1;
        carry_d.old_idx  = IW'(IDX);
        carry_d.old_age  = age_q;
      end
    end
  end

  // Apply fill, aging and invalidation
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (cmd_i.age && valid_q && !match && (age_q != {AGE_WIDTH{1'b1}})) begin
      age_d = age_q + AGE_WIDTH'(1);
    end
    if (cmd_i.inval && sel_i) begin
      valid_d = 1'b0;
    end
    if (cmd_i.fill && sel_i) begin
      valid_d = 1'b1;
      age_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      addr_q  <= '0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      carry_q <= carry_d;
      if (cmd_i.fill && sel_i) begin
        addr_q <= cmd_i.addr;
      end
    end
  end

  // Hold tile and size payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill && sel_i) begin
      tile_q <= cmd_i.tile;
      size_q <= cmd_i.size;
    end
  end

  assign carry_o = CW'(carry_q);

endmodule

// ----- design/tile_cache_age_replacement_top.sv -----
// ----------------------------------------------------------------------------
// tile_cache_age_replacement_top
// Fully associative tile tag store with round-robin or age-based replacement.
// ----------------------------------------------------------------------------
// Fill and round-robin lookup: result in the output register in the cycle after
//   the beat; one beat per cycle while the output drains.
// Age-mode lookup: a search record walks the chain of cells one cell a cycle,
//   from the launch register through every cell's carry register to the output
//   register; no new beat is taken until the result is in the output register.
// Reset clears valid bits, ages, the round-robin pointer and the mode (round
//   robin); no clearing pass is needed.
module tile_cache_age_replacement_top
  import tca_pkg::*;
#(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // fields: source_address[31:0], tile_number[47:32], fill_entry[50:48],
  // fill_size[66:51], zero pad
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // fields: opcode[0]
  input  logic                s_axis_tuser,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // fields: entry_index[2:0], entry_size[18:3], zero pad
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // fields: hit[0]
  output logic                m_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = 1 + 1 + IW + SIZE_W + 1 + IW + 1 + IW + AGE_WIDTH;
  localparam int unsigned XW = (IW > OIDX_W) ? IW : OIDX_W;

  typedef struct packed {
    logic                 live;
    logic                 hit;
    logic [IW-1:0]        hit_idx;
    logic [SIZE_W-1:0]    hit_size;
    logic                 free;
    logic [IW-1:0]        free_idx;
    logic                 old;
    logic [IW-1:0]        old_idx;
    logic [AGE_WIDTH-1:0] old_age;
  } carry_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e               state_q, state_d;
  logic                 mode_q;
  logic [IW-1:0]        rr_q, rr_d;
  logic                 launch_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [TILE_W-1:0]    tile_q;
  logic                 out_valid_q, out_valid_d;
  logic [OIDX_W-1:0]    out_idx_q, out_idx_d;
  logic                 out_hit_q, out_hit_d;
  logic [SIZE_W-1:0]    out_size_q, out_size_d;

  logic                 s_fire;
  logic                 in_op;
  logic [ADDR_W-1:0]    in_addr;
  logic [TILE_W-1:0]    in_tile;
  logic [FENT_W-1:0]    in_fent;
  logic [SIZE_W-1:0]    in_size;
  logic                 launch_d;

  cmd_t                 cmd;
  logic [ENTRIES-1:0]   sel;
  logic [IW-1:0]        sel_idx;
  logic                 sel_en;
  logic [CW-1:0]        chain [ENTRIES+1];
  carry_t               launch_rec, tail;
  logic [XW-1:0]        idx_ext;
  logic [IW-1:0]        pick_idx;

  // Unpack input beat
  assign in_op   = s_axis_tuser;
  assign in_addr = s_axis_tdata[31:0];
  assign in_tile = s_axis_tdata[47:32];
  assign in_fent = s_axis_tdata[50:48];
  assign in_size = s_axis_tdata[66:51];

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Launch an empty search record into the first cell
  always_comb begin
    launch_rec      = '0;
    launch_rec.live = launch_q;
  end
  assign chain[0] = CW'(launch_rec);
  assign tail     = carry_t'(chain[ENTRIES]);

  // Pick the returned entry once the record leaves the last cell
  always_comb begin
    if (tail.hit) begin
      pick_idx = tail.hit_idx;
    end else if (tail.free) begin
      pick_idx = tail.free_idx;
    end else begin
      pick_idx = tail.old_idx;
    end
  end

  // Sequence commands and results
  always_comb begin
    state_d     = state_q;
    rr_d        = rr_q;
    launch_d    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_hit_d   = out_hit_q;
    out_size_d  = out_size_q;
    cmd         = '0;
    cmd.addr    = addr_q;
    cmd.tile    = tile_q;
    sel_idx     = '0;
    sel_en      = 1'b0;
    idx_ext     = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (in_op == OP_FILL) begin
            cmd.fill    = 1'b1;
            cmd.addr    = in_addr;
            cmd.tile    = in_tile;
            cmd.size    = in_size;
            sel_idx     = IW'(in_fent);
            sel_en      = (32'(in_fent) < ENTRIES);
            out_valid_d = 1'b1;
            out_idx_d   = in_fent;
            out_hit_d   = 1'b0;
            out_size_d  = '0;
          end else if (mode_q == MODE_RR) begin
            cmd.inval   = 1'b1;
            sel_idx     = rr_q;
            sel_en      = 1'b1;
            rr_d        = (rr_q == IW'(ENTRIES - 1)) ? '0 : rr_q + IW'(1);
            idx_ext     = XW'(rr_q);
            out_valid_d = 1'b1;
            out_idx_d   = idx_ext[OIDX_W-1:0];
            out_hit_d   = 1'b0;
            out_size_d  = '0;
          end else begin
            launch_d    = 1'b1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tail.live) begin
          cmd.age     = 1'b1;
          cmd.inval   = !tail.hit && !tail.free;
          sel_idx     = tail.old_idx;
          sel_en      = 1'b1;
          idx_ext     = XW'(pick_idx);
          out_valid_d = 1'b1;
          out_idx_d   = idx_ext[OIDX_W-1:0];
          out_hit_d   = tail.hit;
          out_size_d  = tail.hit ? tail.hit_size : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Decode the target cell
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      sel[i] = sel_en && (sel_idx == IW'(i));
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tca_cell #(
      .ENTRIES   (ENTRIES),
      .AGE_WIDTH (AGE_WIDTH),
      .IDX       (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_i   (sel[g]),
      .carry_i (chain[g]),
      .carry_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_RR;
      rr_q        <= '0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_hit_q   <= 1'b0;
      out_size_q  <= '0;
    end else begin
      state_q     <= state_d;
      rr_q        <= rr_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_hit_q   <= out_hit_d;
      out_size_q  <= out_size_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // Hold lookup tag
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      addr_q <= in_addr;
      tile_q <= in_tile;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {{(M_DATA_W - OIDX_W - SIZE_W){1'b0}}, out_size_q, out_idx_q};

endmodule
